// ===== rtl/roulette_wheel_selector_assert.svh =====
// ----------------------------------------------------------------------------
// Roulette wheel selector assertion macros
// Concurrent assertion shorthands that sample on clock and are held off in reset.
// ----------------------------------------------------------------------------
`ifndef ROULETTE_WHEEL_SELECTOR_ASSERT_SVH
`define ROULETTE_WHEEL_SELECTOR_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define RWS_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("roulette wheel selector assertion failed");

// antecedent implies consequent in the next cycle
`define RWS_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("roulette wheel selector assertion failed");

`endif

// ===== rtl/rws_pkg.sv =====
// ----------------------------------------------------------------------------
// Roulette wheel selector package
// Word types, command codes, constants and state encoding.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rws_pkg;

   localparam logic [1:0]  CMD_LOAD   = 2'd0;
   localparam logic [1:0]  CMD_EVAL   = 2'd1;
   localparam logic [1:0]  CMD_SELECT = 2'd2;

   localparam logic        KIND_EVAL   = 1'b0;
   localparam logic        KIND_SELECT = 1'b1;

   localparam logic [16:0] FRAC_ONE  = 17'h10000;
   localparam logic [6:0]  POP_RESET = 7'd64;

   typedef struct packed {
      logic [1:0]  command;
      logic [5:0]  entry_index;
      logic [15:0] fitness;
      logic [16:0] random_fraction;
   } req_type;

   typedef struct packed {
      logic        result_kind;
      logic [5:0]  selected_index;
      logic [21:0] fitness_sum;
      logic [5:0]  best_index;
      logic [15:0] best_fitness;
      logic        best_found;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_WALK,
      ST_DONE
   } state_type;

endpackage

// ===== rtl/roulette_wheel_selector.sv =====
// ----------------------------------------------------------------------------
// Roulette wheel selector
// Fitness table with evaluate (sum and best entry) and fitness-proportionate
// select, walked one entry per cycle through a shared adder and comparator.
// ----------------------------------------------------------------------------
// channel   ports                          word
// req       req_valid / req_stall          req_data  (req_type)
// rsp       rsp_valid / rsp_stall          rsp_data  (rsp_type)
// csr       csr_wr_en                      csr_wr_data (population size)
//
// Load and unused commands leave the block idle. Evaluate walks all n entries
// and select first forms the threshold product on the shared multiplier, n
// being the population in use; the table walk reads one memory entry per
// cycle. Synchronous reset clears control and the stored sum and sets the
// population to 64. A stalled result holds in the output register; new
// loads are taken meanwhile, a finished walk waits for it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module roulette_wheel_selector
   import rws_pkg::*;
#(
   parameter int POP_SIZE = 64,
   parameter int FIT_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data,
   input  logic       csr_wr_en,
   input  logic [6:0] csr_wr_data
);

   localparam int AW = $clog2(POP_SIZE);
   localparam int CW = $clog2(POP_SIZE + 1);
   localparam int SW = FIT_BITS + AW;
   localparam int HW = (SW > 16) ? (SW - 16) : 1;
   localparam int MB = (HW > 16) ? HW : 16;
   localparam int PW = 17 + MB;

   logic [FIT_BITS-1:0] mem [POP_SIZE];

   state_type           state_ff, state_in;
   logic [6:0]          pop_ff;
   logic [CW-1:0]       n_ff, issue_ff, n_start;
   logic                pipe_valid_ff;
   logic [AW-1:0]       pidx_ff;
   logic [FIT_BITS-1:0] rd_data_ff;
   logic                is_sel_ff;
   logic [SW-1:0]       acc_ff, total_ff, thr_ff;
   logic [FIT_BITS-1:0] best_ff;
   logic [AW-1:0]       at_ff;
   logic [16:0]         frac_ff;
   logic [32:0]         prod_lo_ff;
   rsp_type             res_ff, rsp_data_ff;
   logic                rsp_valid_ff, rsp_valid_in;

   logic                accept, out_free, push, walk_on, rd_en;
   logic                walk_done, last, hit, upd;
   logic [SW-1:0]       acc_next;
   logic [FIT_BITS-1:0] best_next;
   logic [AW-1:0]       at_next;
   logic [MB+15:0]      tot_wide;
   logic [MB-1:0]       mul_b;
   logic [PW-1:0]       mul_out;
   logic [FIT_BITS+15:0] fit_ext, best_ext;
   logic [AW+5:0]       idx_ext, pidx_ext, at_ext;
   logic [SW+21:0]      sum_ext;

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign rd_en    = walk_on && (issue_ff < n_ff);

   always_comb begin
      if (pop_ff == 7'd0) begin
         n_start = CW'(1);
      end else if (int'(pop_ff) > POP_SIZE) begin
         n_start = CW'(POP_SIZE);
      end else begin
         n_start = CW'(pop_ff);
      end
   end

   // shared multiplier: low half of the sum first, then the high half
   assign tot_wide = (MB + 16)'(total_ff);
   assign mul_b    = (state_ff == ST_MUL_LO) ? MB'(tot_wide[15:0]) : tot_wide[MB+15:16];
   assign mul_out  = PW'(frac_ff) * PW'(mul_b);

   // shared adder and comparators of the walk
   assign acc_next  = acc_ff + SW'(rd_data_ff);
   assign upd       = !is_sel_ff && (rd_data_ff > best_ff);
   assign best_next = upd ? rd_data_ff : best_ff;
   assign at_next   = upd ? pidx_ff : at_ff;
   assign last      = (CW'(pidx_ff) == (n_ff - CW'(1)));
   assign hit       = is_sel_ff && (thr_ff <= acc_next);
   assign walk_done = walk_on && pipe_valid_ff && (last || hit);

   assign fit_ext  = (FIT_BITS + 16)'(req_data.fitness);
   assign idx_ext  = (AW + 6)'(req_data.entry_index);
   assign pidx_ext = (AW + 6)'(pidx_ff);
   assign at_ext   = (AW + 6)'(at_next);
   assign sum_ext  = (SW + 22)'(acc_next);
   assign best_ext = (FIT_BITS + 16)'(best_next);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_data.command)
                  CMD_EVAL:   state_in = ST_WALK;
                  CMD_SELECT: state_in = ST_MUL_LO;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_MUL_LO: state_in = ST_MUL_HI;
         ST_MUL_HI: state_in = ST_WALK;
         ST_WALK: begin
            if (walk_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall = 1'b1;
      push      = 1'b0;
      walk_on   = 1'b0;
      unique case (state_ff)
         ST_IDLE:   req_stall = 1'b0;
         ST_MUL_LO: req_stall = 1'b1;
         ST_MUL_HI: req_stall = 1'b1;
         ST_WALK:   walk_on   = 1'b1;
         ST_DONE:   push      = out_free;
         default:   req_stall = 1'b1;
      endcase
   end

   assign rsp_valid_in = push || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pop_ff        <= POP_RESET;
         total_ff      <= '0;
         pipe_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         pipe_valid_ff <= rd_en && !walk_done;
         if (csr_wr_en) begin
            pop_ff <= csr_wr_data;
         end
         if (walk_done && !is_sel_ff) begin
            total_ff <= acc_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && (req_data.command == CMD_LOAD) && (int'(req_data.entry_index) < POP_SIZE)) begin
         mem[idx_ext[AW-1:0]] <= fit_ext[FIT_BITS-1:0];
      end
      if (rd_en) begin
         rd_data_ff <= mem[issue_ff[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         n_ff      <= n_start;
         is_sel_ff <= (req_data.command == CMD_SELECT);
         frac_ff   <= (req_data.random_fraction > FRAC_ONE) ? FRAC_ONE
                                                            : req_data.random_fraction;
         issue_ff  <= '0;
         acc_ff    <= '0;
         best_ff   <= '0;
         at_ff     <= '0;
      end
      if (state_ff == ST_MUL_LO) begin
         prod_lo_ff <= mul_out[32:0];
      end
      if (state_ff == ST_MUL_HI) begin
         thr_ff <= SW'(mul_out + PW'(prod_lo_ff[32:16]));
      end
      if (rd_en) begin
         issue_ff <= issue_ff + CW'(1);
         pidx_ff  <= issue_ff[AW-1:0];
      end
      if (walk_on && pipe_valid_ff) begin
         acc_ff  <= acc_next;
         best_ff <= best_next;
         at_ff   <= at_next;
      end
      if (walk_done) begin
         res_ff.result_kind    <= is_sel_ff ? KIND_SELECT : KIND_EVAL;
         res_ff.selected_index <= is_sel_ff ? pidx_ext[5:0] : 6'd0;
         res_ff.fitness_sum    <= is_sel_ff ? 22'd0 : sum_ext[21:0];
         res_ff.best_index     <= is_sel_ff ? 6'd0 : at_ext[5:0];
         res_ff.best_fitness   <= is_sel_ff ? 16'd0 : best_ext[15:0];
         res_ff.best_found     <= !is_sel_ff && (best_next != '0);
      end
      if (push) begin
         rsp_data_ff <= res_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/rws_checker.sv =====
// ----------------------------------------------------------------------------
// Roulette wheel selector checker
// Port-level assertions on result words, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "roulette_wheel_selector_assert.svh"

module rws_checker
   import rws_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   `RWS_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

   `RWS_ASSERT_IMP(a_sel_clean, rsp_valid && (rsp_data.result_kind == KIND_SELECT), (rsp_data.fitness_sum == 22'd0) && (rsp_data.best_index == 6'd0) && (rsp_data.best_fitness == 16'd0) && !rsp_data.best_found)

   `RWS_ASSERT_IMP(a_eval_best, rsp_valid && (rsp_data.result_kind == KIND_EVAL), (rsp_data.selected_index == 6'd0) && (rsp_data.best_found == (rsp_data.best_fitness != 16'd0)) && (rsp_data.best_found || (rsp_data.best_index == 6'd0)))

   `RWS_ASSERT_NEXT(a_load_quiet, req_valid && !req_stall && (req_data.command == CMD_LOAD) && !rsp_valid, !rsp_valid)

endmodule

bind roulette_wheel_selector rws_checker u_rws_checker (.*);
